FILE: sv/csvt_pkg.sv
package csvt_pkg;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [7:0] DELIM_RESET = 8'd44;
   localparam logic [7:0] CH_QUOTE    = 8'h22;
   localparam logic [7:0] CH_BSLASH   = 8'h5C;
   localparam logic [7:0] CH_T        = 8'h74;
   localparam logic [7:0] CH_N        = 8'h6E;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_LF       = 8'h0A;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_EOL  = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] in_byte;
   } csvt_item_type;

   typedef struct packed {
      logic       in_quotes;
      logic       escape_pending;
      logic       header_done;
   } csvt_state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_field_end;
      logic       is_line_end;
      logic       from_header_line;
      logic       last_of_run;
   } csvt_rsp_type;

   typedef struct packed {
      logic [1:0]     count;
      csvt_rsp_type   rsp0;
      csvt_rsp_type   rsp1;
      csvt_state_type state_next;
   } csvt_decode_type;

endpackage

FILE: sv/csvt_decode.sv
module csvt_decode
   import csvt_pkg::*;
(
   input  csvt_item_type   item,
   input  logic [7:0]      delimiter,
   input  csvt_state_type  state,
   output csvt_decode_type dec
);

   typedef struct packed {
      logic emit;
      logic fend;
      logic toggle;
      logic hold;
   } plain_type;

   function automatic plain_type plain_fn(input logic [7:0] c, input logic [7:0] delim,
                                          input logic inq);
      plain_type p;
      p = '0;
      if (c == CH_QUOTE) begin
         p.toggle = 1'b1;
      end else if (c == delim && !inq) begin
         p.emit = 1'b1;
         p.fend = 1'b1;
      end else if (c == CH_BSLASH) begin
         p.hold = 1'b1;
      end else begin
         p.emit = 1'b1;
      end
      return p;
   endfunction

   function automatic csvt_rsp_type mk_rsp(input logic [7:0] b, input logic fend,
                                           input logic lend, input logic hdr);
      csvt_rsp_type r;
      r.out_byte         = b;
      r.is_field_end     = fend;
      r.is_line_end      = lend;
      r.from_header_line = hdr;
      r.last_of_run      = 1'b0;
      return r;
   endfunction

   plain_type    p;
   csvt_rsp_type plain_rsp;
   logic         hdr;
   logic [7:0]   c;

   assign c   = item.in_byte;
   assign hdr = ~state.header_done;

   always_comb begin
      p         = plain_fn(c, delimiter, state.in_quotes);
      plain_rsp = mk_rsp(p.fend ? 8'd0 : c, p.fend, 1'b0, hdr);
      dec                      = '0;
      dec.state_next           = state;
      if (item.kind == KIND_EOL) begin
         dec.state_next.in_quotes      = 1'b0;
         dec.state_next.escape_pending = 1'b0;
         dec.state_next.header_done    = 1'b1;
         if (state.escape_pending) begin
            dec.rsp0  = mk_rsp(CH_BSLASH, 1'b0, 1'b0, hdr);
            dec.rsp1  = mk_rsp(8'd0, 1'b1, 1'b1, hdr);
            dec.count = 2'd2;
         end else begin
            dec.rsp0  = mk_rsp(8'd0, 1'b1, 1'b1, hdr);
            dec.count = 2'd1;
         end
      end else if (state.escape_pending) begin
         dec.state_next.escape_pending = 1'b0;
         dec.count = 2'd1;
         if (c == CH_T) begin
            dec.rsp0 = mk_rsp(CH_TAB, 1'b0, 1'b0, hdr);
         end else if (c == CH_N) begin
            dec.rsp0 = mk_rsp(CH_LF, 1'b0, 1'b0, hdr);
         end else if (c == CH_QUOTE || c == CH_BSLASH) begin
            dec.rsp0 = mk_rsp(c, 1'b0, 1'b0, hdr);
         end else begin
            dec.rsp0 = mk_rsp(CH_BSLASH, 1'b0, 1'b0, hdr);
            dec.rsp1 = plain_rsp;
            dec.count = p.emit ? 2'd2 : 2'd1;
            dec.state_next.in_quotes      = state.in_quotes ^ p.toggle;
            dec.state_next.escape_pending = p.hold;
         end
      end else begin
         dec.rsp0 = plain_rsp;
         dec.count = p.emit ? 2'd1 : 2'd0;
         dec.state_next.in_quotes      = state.in_quotes ^ p.toggle;
         dec.state_next.escape_pending = p.hold;
      end
      if (dec.count == 2'd1) begin
         dec.rsp0.last_of_run = 1'b1;
      end
      if (dec.count == 2'd2) begin
         dec.rsp1.last_of_run = 1'b1;
      end
   end

endmodule

FILE: sv/csvt_rsp_fifo.sv
module csvt_rsp_fifo
   import csvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   push_count,
   input  csvt_rsp_type push0,
   input  csvt_rsp_type push1,
   output logic         room_two,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output csvt_rsp_type rsp,
   output logic [RSP_CNT_W-1:0] fill
);

   csvt_rsp_type         mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop;
   logic [RSP_PTR_W-1:0] wr_ptr_next;

   assign rsp_valid   = (count_ff != '0);
   assign rsp         = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign room_two    = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign fill        = count_ff;
   assign wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push_count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: sv/csv_field_tokenizer_unit.sv
// A request passes through the request stage register and the result queue to rsp_valid.
// Throughput: 1 request per cycle while each request yields at most one result and
// rsp_stall is low; a request that yields two results sends them out one at a time.
// The result queue holds 4 entries; the request stage advances with at least 2 free.
// Reset: synchronous, active high; clears quote, escape and header state and sets
// the delimiter to 44.
module csv_field_tokenizer_unit
   import csvt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_kind,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_field_end,
   output logic       rsp_is_line_end,
   output logic       rsp_from_header_line,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_delimiter
);

   logic            stage_vld_ff, stage_vld_in;
   csvt_item_type   stage_ff, stage_in;
   csvt_state_type  state_ff, state_in;
   logic [7:0]      delim_ff, delim_in;
   csvt_decode_type dec;
   csvt_rsp_type    rsp;
   logic            room_two;
   logic            advance;
   logic            accept;
   logic [1:0]      push_count;
   logic [RSP_CNT_W-1:0] fill;

   assign csr_ready  = 1'b1;
   assign advance    = stage_vld_ff && room_two;
   assign req_stall  = stage_vld_ff && !room_two;
   assign accept     = req_valid && !req_stall;
   assign push_count = advance ? dec.count : 2'd0;

   always_comb begin
      stage_vld_in = accept ? 1'b1 : (advance ? 1'b0 : stage_vld_ff);
      stage_in     = accept ? {req_kind, req_in_byte} : stage_ff;
      state_in     = advance ? dec.state_next : state_ff;
      delim_in     = (csr_valid && csr_ready) ? csr_delimiter : delim_ff;
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
         state_ff     <= '0;
         delim_ff     <= DELIM_RESET;
      end else begin
         stage_vld_ff <= stage_vld_in;
         state_ff     <= state_in;
         delim_ff     <= delim_in;
      end
   end

   csvt_decode u_decode (
      .item      (stage_ff),
      .delimiter (delim_ff),
      .state     (state_ff),
      .dec       (dec)
   );

   csvt_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push0      (dec.rsp0),
      .push1      (dec.rsp1),
      .room_two   (room_two),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp        (rsp),
      .fill       (fill)
   );

   assign rsp_out_byte         = rsp.out_byte;
   assign rsp_is_field_end     = rsp.is_field_end;
   assign rsp_is_line_end      = rsp.is_line_end;
   assign rsp_from_header_line = rsp.from_header_line;
   assign rsp_last_of_run      = rsp.last_of_run;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   a_line_end_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_line_end |-> rsp_is_field_end && rsp_last_of_run)
      else $error("line end result not final field end");

   a_field_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_field_end |-> rsp_out_byte == 8'd0)
      else $error("field end carries data");

   a_eol_sets_header: assert property (@(posedge clock) disable iff (reset)
      advance && stage_ff.kind == KIND_EOL |=> state_ff.header_done
         && !state_ff.in_quotes && !state_ff.escape_pending)
      else $error("end of line did not reset line state");

endmodule

FILE: bench/csv_field_tokenizer_unit_tb.sv
`timescale 1ns / 1ps

import csvt_pkg::*;

class tokenizer_scoreboard;
   logic [7:0]   delimiter;
   bit           in_quotes;
   bit           escape_pending;
   bit           header_done;
   csvt_rsp_type expected_tokens[$];
   int           mismatches;
   int           request_count;
   int           token_count;
   int           line_count;
   int           escape_count;

   function new();
      delimiter      = DELIM_RESET;
      in_quotes      = 1'b0;
      escape_pending = 1'b0;
      header_done    = 1'b0;
      mismatches     = 0;
      request_count  = 0;
      token_count    = 0;
      line_count     = 0;
      escape_count   = 0;
   endfunction

   function void push_token(logic [7:0] data, bit field_end, bit line_end);
      csvt_rsp_type tok;
      tok.out_byte         = data;
      tok.is_field_end     = field_end;
      tok.is_line_end      = line_end;
      tok.from_header_line = !header_done;
      tok.last_of_run      = 1'b0;
      expected_tokens = {expected_tokens, tok};
   endfunction

   function void plain_char(logic [7:0] c);
      if (c == CH_QUOTE) begin
         in_quotes = !in_quotes;
      end else if (c == delimiter && !in_quotes) begin
         push_token(8'h00, 1'b1, 1'b0);
      end else if (c == CH_BSLASH) begin
         escape_pending = 1'b1;
      end else begin
         push_token(c, 1'b0, 1'b0);
      end
   endfunction

   function void note_request(logic kind, logic [7:0] data);
      int depth_before;
      depth_before = expected_tokens.size();
      request_count++;
      if (kind == KIND_EOL) begin
         if (escape_pending) begin
            push_token(CH_BSLASH, 1'b0, 1'b0);
         end
         push_token(8'h00, 1'b1, 1'b1);
         in_quotes      = 1'b0;
         escape_pending = 1'b0;
         header_done    = 1'b1;
         line_count++;
      end else if (escape_pending) begin
         escape_pending = 1'b0;
         escape_count++;
         case (data)
            CH_T: begin
               push_token(CH_TAB, 1'b0, 1'b0);
            end
            CH_N: begin
               push_token(CH_LF, 1'b0, 1'b0);
            end
            CH_QUOTE, CH_BSLASH: begin
               push_token(data, 1'b0, 1'b0);
            end
            default: begin
               push_token(CH_BSLASH, 1'b0, 1'b0);
               plain_char(data);
            end
         endcase
      end else begin
         plain_char(data);
      end
      if (expected_tokens.size() > depth_before) begin
         expected_tokens[expected_tokens.size() - 1].last_of_run = 1'b1;
      end
   endfunction

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   function void check_result(csvt_rsp_type got);
      csvt_rsp_type want;
      if (expected_tokens.size() == 0) begin
         $error("result with none expected: out_byte %0h", got.out_byte);
         mismatches++;
      end else begin
         want = expected_tokens.pop_front();
         token_count++;
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("is_field_end", 8'(want.is_field_end), 8'(got.is_field_end));
         compare_field("is_line_end", 8'(want.is_line_end), 8'(got.is_line_end));
         compare_field("from_header_line", 8'(want.from_header_line),
                       8'(got.from_header_line));
         compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
      end
   endfunction
endclass

module csv_field_tokenizer_unit_tb;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 120;
   localparam int SETTLE_CYCLES  = 6;

   logic       clock                = 1'b0;
   logic       reset                = 1'b1;
   logic       req_valid            = 1'b0;
   logic       req_stall;
   logic       req_kind             = KIND_BYTE;
   logic [7:0] req_in_byte          = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall            = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_field_end;
   logic       rsp_is_line_end;
   logic       rsp_from_header_line;
   logic       rsp_last_of_run;
   logic       csr_valid            = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_delimiter        = DELIM_RESET;

   bit  calm             = 1'b0;
   int  long_hold_cycles = 0;
   int  idle_cycles      = 0;
   int  settings_used    = 1;
   tokenizer_scoreboard sb;

   csv_field_tokenizer_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_kind             (req_kind),
      .req_in_byte          (req_in_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_is_field_end     (rsp_is_field_end),
      .rsp_is_line_end      (rsp_is_line_end),
      .rsp_from_header_line (rsp_from_header_line),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_delimiter        (csr_delimiter)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result({rsp_out_byte, rsp_is_field_end, rsp_is_line_end,
                          rsp_from_header_line, rsp_last_of_run});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (long_hold_cycles) @(negedge clock);
            long_hold_cycles = 0;
            rsp_stall <= 1'b0;
         end else if (calm || $urandom_range(0, 3) != 0) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17) - 1) @(negedge clock);
         end
      end
   end

   task automatic send_request(input logic kind, input logic [7:0] data);
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_in_byte <= data;
      do @(posedge clock); while (req_stall);
      sb.note_request(kind, data);
      @(negedge clock);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_tokens.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_delimiter(input logic [7:0] value);
      csr_valid     <= 1'b1;
      csr_delimiter <= value;
      do @(posedge clock); while (!csr_ready);
      sb.delimiter = value;
      settings_used++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_char();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 8'h61 + 8'($urandom_range(0, 25));
      if (roll < 55) return sb.delimiter;
      if (roll < 65) return CH_QUOTE;
      if (roll < 75) return CH_BSLASH;
      if (roll < 80) return CH_T;
      if (roll < 85) return CH_N;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_line();
      int fields;
      if ($urandom_range(0, 9) == 0) begin
         // noise: raw kinds and bytes, possibly no closing end of line
         repeat ($urandom_range(1, 12)) begin
            send_request(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         end
      end else begin
         fields = $urandom_range(1, 5);
         for (int f = 0; f < fields; f++) begin
            repeat ($urandom_range(0, 6)) send_request(KIND_BYTE, pick_char());
            if (f < fields - 1) begin
               send_request(KIND_BYTE, sb.delimiter);
            end
         end
         send_request(KIND_EOL, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic random_phase(input int target);
      int start;
      start = sb.request_count;
      while (sb.request_count - start < target) send_line();
   endtask

   initial begin
      logic [7:0] settings[6];
      sb = new();
      settings = '{8'h00, 8'hFF, CH_QUOTE, CH_BSLASH, CH_TAB, 8'h00};
      settings[5] = 8'($urandom_range(0, 255));
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(KIND_BYTE, "a");
      send_request(KIND_BYTE, DELIM_RESET);
      send_request(KIND_BYTE, CH_QUOTE);
      send_request(KIND_BYTE, DELIM_RESET);
      send_request(KIND_BYTE, "b");
      send_request(KIND_BYTE, CH_QUOTE);
      send_request(KIND_BYTE, CH_BSLASH);
      send_request(KIND_BYTE, CH_T);
      send_request(KIND_BYTE, CH_BSLASH);
      send_request(KIND_BYTE, CH_N);
      send_request(KIND_BYTE, CH_BSLASH);
      send_request(KIND_BYTE, CH_QUOTE);
      send_request(KIND_BYTE, CH_BSLASH);
      send_request(KIND_BYTE, CH_BSLASH);
      send_request(KIND_BYTE, CH_BSLASH);
      send_request(KIND_BYTE, "x");
      send_request(KIND_BYTE, CH_BSLASH);
      send_request(KIND_BYTE, DELIM_RESET);
      send_request(KIND_BYTE, 8'h00);
      send_request(KIND_BYTE, 8'hFF);
      send_request(KIND_BYTE, CH_BSLASH);
      send_request(KIND_EOL, 8'h00);
      send_request(KIND_EOL, 8'hFF);
      send_request(KIND_BYTE, CH_QUOTE);
      send_request(KIND_BYTE, "q");
      send_request(KIND_EOL, 8'h5A);
      wait_idle();

      // hold the result side while requests keep coming
      long_hold_cycles = LONG_HOLD;
      calm = 1'b1;
      repeat (40) send_request(KIND_BYTE, pick_char());
      calm = 1'b0;
      wait_idle();

      random_phase(180);
      wait_idle();

      foreach (settings[i]) begin
         write_delimiter(settings[i]);
         send_request(KIND_BYTE, "x");
         send_request(KIND_BYTE, settings[i]);
         send_request(KIND_BYTE, CH_QUOTE);
         send_request(KIND_BYTE, settings[i]);
         send_request(KIND_BYTE, CH_BSLASH);
         send_request(KIND_BYTE, settings[i]);
         send_request(KIND_BYTE, CH_QUOTE);
         send_request(KIND_EOL, 8'h00);
         random_phase(170);
         wait_idle();
      end

      write_delimiter(DELIM_RESET);
      calm = 1'b1;
      random_phase(150);
      wait_idle();

      $display("Covered %0d requests, %0d results, %0d lines and %0d escapes,",
               sb.request_count, sb.token_count, sb.line_count, sb.escape_count);
      $display("across %0d delimiter settings including 0, 255, quote and backslash.",
               settings_used);
      if (sb.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
